@@ design/nps_pkg.sv @@
package nps_pkg;

    localparam int MAX_FIELDS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int FIU_W  = 7;
    localparam int IDX_W  = 6;
    localparam int DIST_W = 34;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [FIU_W-1:0]  fiu_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;

endpackage

@@ design/nps_req_if.sv @@
interface nps_req_if
    import nps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    idx_t                          entry_index;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (
        output valid, req_type, entry_index, coord_x, coord_y, coord_z,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

@@ design/nps_rsp_if.sv @@
interface nps_rsp_if
    import nps_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  found;
    idx_t  nearest_index;
    dist_t min_distance_sq;

    modport source (
        output valid, found, nearest_index, min_distance_sq,
        input  ready
    );

    modport sink (
        input  valid, found, nearest_index, min_distance_sq,
        output ready
    );
endinterface

@@ design/nps_cfg_if.sv @@
interface nps_cfg_if
    import nps_pkg::*;
();
    logic valid;
    logic ready;
    fiu_t data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ design/nearest_point_search_core.sv @@
// Write beats give no result.
// A query streams its searched entries through the table read register and the
// distance pipeline; an empty search goes straight to the result. Ready returns as
// the result enters the output register, so queries are accepted one at a time.
// Throughput is one table entry per cycle, set by the single read port of the table.
// Reset clears control state and fields_in_use; table contents stay undefined
// until written.
module nearest_point_search_core
    import nps_pkg::*;
#(
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nps_req_if.sink   req,
    nps_rsp_if.source rsp,
    nps_cfg_if.sink   cfg
);

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CNT_W  = $clog2(MAX_FIELDS + 1);
    localparam int CMP_W  = (CNT_W > FIU_W) ? CNT_W : FIU_W;
    localparam int SLOT_W = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
    localparam int DW     = 2 * CW + 2;
    localparam int EW     = (DW > DIST_W) ? DW : DIST_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    fiu_t             fiu_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;

    logic signed [CW-1:0] qx_reg;
    logic signed [CW-1:0] qy_reg;
    logic signed [CW-1:0] qz_reg;

    logic          rd_valid_reg;
    logic          rd_last_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          best_found_reg;
    logic [DW-1:0] best_dist_reg;
    logic [AW-1:0] best_idx_reg;

    logic  rsp_valid_reg;
    logic  rsp_found_reg;
    idx_t  rsp_idx_reg;
    dist_t rsp_dist_reg;

    logic              req_fire;
    logic              is_query;
    logic              ram_we;
    logic              ram_re;
    logic              scan_last;
    logic              rsp_load;
    logic [3*CW-1:0]   ram_rdata;
    logic [CMP_W-1:0]  fiu_ext;
    logic              d_valid;
    logic              d_last;
    logic [AW-1:0]     d_idx;
    logic [DW-1:0]     d_dist;
    logic              take_best;
    logic [EW-1:0]     best_ext;
    dist_t             best_sat;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign is_query  = (req.req_type == REQ_QUERY);
    assign ram_we    = req_fire && !is_query
                       && (SLOT_W'(req.entry_index) < SLOT_W'(MAX_FIELDS));
    assign ram_re    = (state_reg == S_SCAN);
    assign scan_last = (CNT_W'(scan_reg + 1'b1) == count_reg);
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign fiu_ext   = CMP_W'(fiu_reg);
    assign count_next = (fiu_ext > CMP_W'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS)
                                                       : CNT_W'(fiu_ext);

    nps_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_FIELDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(req.entry_index)),
        .wdata ({req.coord_x, req.coord_y, req.coord_z}),
        .re    (ram_re),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    nps_dist #(
        .COORD_WIDTH (CW),
        .ADDR_W      (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_last   (rd_last_reg),
        .in_idx    (rd_idx_reg),
        .point     (ram_rdata),
        .query_x   (qx_reg),
        .query_y   (qy_reg),
        .query_z   (qz_reg),
        .out_valid (d_valid),
        .out_last  (d_last),
        .out_idx   (d_idx),
        .out_dist  (d_dist)
    );

    assign take_best = d_valid && (!best_found_reg || (d_dist < best_dist_reg));

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && is_query)
                begin
                    scan_next  = '0;
                    state_next = (count_next == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = CNT_W'(scan_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                if (d_valid && d_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            count_reg      <= '0;
            fiu_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= ram_re;
            rd_last_reg  <= ram_re && scan_last;
            if (cfg.valid && cfg.ready)
            begin
                fiu_reg <= cfg.data;
            end
            if (req_fire && is_query)
            begin
                count_reg      <= count_next;
                best_found_reg <= 1'b0;
            end
            else if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign best_ext = EW'(best_dist_reg);
    assign best_sat = (best_ext > EW'(DIST_MAX)) ? DIST_MAX : best_ext[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg[AW-1:0];
        if (req_fire && is_query)
        begin
            qx_reg <= req.coord_x;
            qy_reg <= req.coord_y;
            qz_reg <= req.coord_z;
        end
        if (take_best)
        begin
            best_dist_reg <= d_dist;
            best_idx_reg  <= d_idx;
        end
        if (rsp_load)
        begin
            rsp_found_reg <= best_found_reg;
            rsp_idx_reg   <= best_found_reg ? IDX_W'(best_idx_reg) : '0;
            rsp_dist_reg  <= best_found_reg ? best_sat : '0;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.found           = rsp_found_reg;
    assign rsp.nearest_index   = rsp_idx_reg;
    assign rsp.min_distance_sq = rsp_dist_reg;

endmodule

@@ design/nps_ram.sv @@
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nps_dist.sv @@
module nps_dist
    import nps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ADDR_W      = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_last,
    input  logic [ADDR_W-1:0]             in_idx,
    input  logic [3*COORD_WIDTH-1:0]      point,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    output logic                          out_valid,
    output logic                          out_last,
    output logic [ADDR_W-1:0]             out_idx,
    output logic [2*COORD_WIDTH+1:0]      out_dist
);

    localparam int CW   = COORD_WIDTH;
    localparam int SQ_W = 2 * CW;
    localparam int DW   = 2 * CW + 2;

    logic signed [CW-1:0] pt_x;
    logic signed [CW-1:0] pt_y;
    logic signed [CW-1:0] pt_z;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic signed [CW:0]   dz;

    logic [2:0]        valid_reg;
    logic [2:0]        last_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic [ADDR_W-1:0] idx2_reg;
    logic [ADDR_W-1:0] idx3_reg;
    logic [CW-1:0]     mx_reg;
    logic [CW-1:0]     my_reg;
    logic [CW-1:0]     mz_reg;
    logic [SQ_W-1:0]   sx_reg;
    logic [SQ_W-1:0]   sy_reg;
    logic [SQ_W-1:0]   sz_reg;
    logic [DW-1:0]     sum_reg;

    assign pt_x = point[3*CW-1:2*CW];
    assign pt_y = point[2*CW-1:CW];
    assign pt_z = point[CW-1:0];

    assign dx = $signed({query_x[CW-1], query_x}) - $signed({pt_x[CW-1], pt_x});
    assign dy = $signed({query_y[CW-1], query_y}) - $signed({pt_y[CW-1], pt_y});
    assign dz = $signed({query_z[CW-1], query_z}) - $signed({pt_z[CW-1], pt_z});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
            last_reg  <= {last_reg[1:0], in_last};
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= CW'(dx[CW] ? -dx : dx);
        my_reg   <= CW'(dy[CW] ? -dy : dy);
        mz_reg   <= CW'(dz[CW] ? -dz : dz);
        idx1_reg <= in_idx;

        sx_reg   <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
        sy_reg   <= SQ_W'(my_reg) * SQ_W'(my_reg);
        sz_reg   <= SQ_W'(mz_reg) * SQ_W'(mz_reg);
        idx2_reg <= idx1_reg;

        sum_reg  <= DW'(sx_reg) + DW'(sy_reg) + DW'(sz_reg);
        idx3_reg <= idx2_reg;
    end

    assign out_valid = valid_reg[2];
    assign out_last  = last_reg[2];
    assign out_idx   = idx3_reg;
    assign out_dist  = sum_reg;

endmodule
